// File: rtl/apag_pkg.sv
// Package for the pitch angle and gyro rate block: widths, pipeline sizes,
// the CORDIC arctangent table and the configuration register codes.
// Depends on nothing; every other file of the block imports it.
package apag_pkg;

  localparam int IN_W     = 16;
  localparam int RATE_W   = 24;
  localparam int RECIP_W  = 24;
  localparam int ANGLE_W  = 16;

  // Integer square root of (ay^2 + az^2) * 2^16.
  localparam int SQ_W     = 2 * IN_W;            // ay^2 + az^2
  localparam int REM_W    = SQ_W + 16;           // radicand
  localparam int ROOT_W   = REM_W / 2;           // root bits, one cell each
  localparam int TRIAL_W  = REM_W + 2;
  localparam int BIT_W    = $clog2(ROOT_W);

  // CORDIC datapath.
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_CELLS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(TABLE_LEN);
  localparam int X_W          = ROOT_W + 3;      // headroom for the CORDIC gain
  localparam int Z_W          = 24;
  localparam int ATAN_W       = Z_W - 1;

  localparam int ANGLE_LIMIT  = 23040;           // 90 degrees in Q8.8
  localparam int LATENCY      = 3 + ROOT_W + CORDIC_CELLS;

  localparam logic [RECIP_W-1:0] RATE_RECIP_RESET = RECIP_W'(128075);

  // atan(2^-i) in degrees, Q16.
  localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
    ATAN_W'(2949120), ATAN_W'(1740967), ATAN_W'(919879), ATAN_W'(466945),
    ATAN_W'(234379),  ATAN_W'(117304),  ATAN_W'(58666),  ATAN_W'(29335),
    ATAN_W'(14668),   ATAN_W'(7334),    ATAN_W'(3667),   ATAN_W'(1833),
    ATAN_W'(917),     ATAN_W'(458),     ATAN_W'(229),    ATAN_W'(115),
    ATAN_W'(57),      ATAN_W'(29),      ATAN_W'(14),     ATAN_W'(7),
    ATAN_W'(4),       ATAN_W'(2),       ATAN_W'(1),      ATAN_W'(0)
  };

  typedef enum logic [1:0] {
    REG_NEGATE_ANGLE = 2'd0,
    REG_NEGATE_RATE  = 2'd1,
    REG_RATE_RECIP   = 2'd2
  } cfg_reg_e;

  // Data that rides along with an item through the cell chains.
  typedef struct packed {
    logic                     zero;  // all three accelerometer axes are zero
    logic signed [RATE_W-1:0] rate;  // finished gyro rate
  } tag_t;

endpackage

// File: rtl/apag_sqrt_cell.sv
// One cell of the pipelined integer square root: decides one root bit.
// Depends on apag_pkg.
module apag_sqrt_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [apag_pkg::BIT_W-1:0]    bit_i,
  input  logic                          valid_i,
  input  logic [apag_pkg::REM_W-1:0]    rem_i,
  input  logic [apag_pkg::ROOT_W-1:0]   root_i,
  input  logic signed [apag_pkg::IN_W-1:0] ax_i,
  input  apag_pkg::tag_t                tag_i,
  output logic                          valid_o,
  output logic [apag_pkg::REM_W-1:0]    rem_o,
  output logic [apag_pkg::ROOT_W-1:0]   root_o,
  output logic signed [apag_pkg::IN_W-1:0] ax_o,
  output apag_pkg::tag_t                tag_o
);
  import apag_pkg::*;

  logic [TRIAL_W-1:0] trial;
  logic               fits;
  logic [REM_W-1:0]   rem_d;
  logic [ROOT_W-1:0]  root_d;
  logic               valid_q;
  logic [REM_W-1:0]   rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic signed [IN_W-1:0] ax_q;
  tag_t               tag_q;

  // (q + 2^k)^2 - q^2 = q * 2^(k+1) + 2^(2k)
  assign trial  = (TRIAL_W'(root_i) << (BIT_W + 1)'(bit_i + 1'b1))
                + (TRIAL_W'(1) << {bit_i, 1'b0});
  assign fits   = TRIAL_W'(rem_i) >= trial;
  assign rem_d  = fits ? REM_W'(TRIAL_W'(rem_i) - trial) : rem_i;
  assign root_d = fits ? (root_i | (ROOT_W'(1) << bit_i)) : root_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    ax_q   <= ax_i;
    tag_q  <= tag_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign ax_o    = ax_q;
  assign tag_o   = tag_q;

endmodule

// File: rtl/apag_cordic_cell.sv
// One vectoring CORDIC micro-rotation, registered, for the pitch angle chain.
// Depends on apag_pkg (widths and the arctangent table).
module apag_cordic_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [apag_pkg::STEP_W-1:0]    step_i,
  input  logic                           valid_i,
  input  logic signed [apag_pkg::X_W-1:0] x_i,
  input  logic signed [apag_pkg::X_W-1:0] y_i,
  input  logic signed [apag_pkg::Z_W-1:0] z_i,
  input  apag_pkg::tag_t                 tag_i,
  output logic                           valid_o,
  output logic signed [apag_pkg::X_W-1:0] x_o,
  output logic signed [apag_pkg::X_W-1:0] y_o,
  output logic signed [apag_pkg::Z_W-1:0] z_o,
  output apag_pkg::tag_t                 tag_o
);
  import apag_pkg::*;

  logic                  y_pos;
  logic signed [X_W-1:0] xs;
  logic signed [X_W-1:0] ys;
  logic signed [Z_W-1:0] ang;
  logic                  valid_q;
  logic signed [X_W-1:0] x_q;
  logic signed [X_W-1:0] y_q;
  logic signed [Z_W-1:0] z_q;
  tag_t                  tag_q;

  assign y_pos = !y_i[X_W-1] && (y_i != '0);
  assign xs    = x_i >>> step_i;
  assign ys    = y_i >>> step_i;
  assign ang   = $signed({1'b0, ATAN_DEG_Q16[step_i]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Both updates use the values from before the step.
  always_ff @(posedge clk_i) begin
    if (y_pos) begin
      x_q <= x_i + ys;
      y_q <= y_i - xs;
      z_q <= z_i + ang;
    end else begin
      x_q <= x_i - ys;
      y_q <= y_i + xs;
      z_q <= z_i - ang;
    end
    tag_q <= tag_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign tag_o   = tag_q;

endmodule

// File: rtl/accel_pitch_angle_and_gyro_rate.sv
// Top level of the pitch angle and gyro rate block.
// Depends on apag_pkg, apag_sqrt_cell and apag_cordic_cell.

// The block takes one raw sample (three accelerometer axes and one gyro
// axis) per item and returns one result per item, in order. It never
// stalls: busy stays low, so an item may be started in every clock cycle,
// and each result appears on pitch_angle_o and pitch_rate_o for exactly one
// cycle with result_valid_o high; the receiver must take it then. From the
// accepting edge to the result, an item passes stage one (squares and gyro
// product), stage two (radicand and rate), one square-root cell per root
// bit (24), one CORDIC cell per micro-rotation (16) and the output
// register. Configuration writes take effect at once and should only be
// made while no item is in flight.
module accel_pitch_angle_and_gyro_rate (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [apag_pkg::IN_W-1:0]   accel_x_i,
  input  logic signed [apag_pkg::IN_W-1:0]   accel_y_i,
  input  logic signed [apag_pkg::IN_W-1:0]   accel_z_i,
  input  logic signed [apag_pkg::IN_W-1:0]   gyro_pitch_i,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [apag_pkg::RECIP_W-1:0]       cfg_wdata_i,
  output logic                               result_valid_o,
  output logic signed [apag_pkg::ANGLE_W-1:0] pitch_angle_o,
  output logic signed [apag_pkg::RATE_W-1:0]  pitch_rate_o
);
  import apag_pkg::*;

  localparam int PROD_W = IN_W + RECIP_W + 1;

  // Configuration registers.
  logic               negate_angle_q;
  logic               negate_rate_q;
  logic [RECIP_W-1:0] rate_recip_q;

  // First stage: squares, gyro product and the all-zero flag.
  logic                    in_accept;
  logic                    s1_valid_q;
  logic [SQ_W-2:0]         s1_ay_sq_q;
  logic [SQ_W-2:0]         s1_az_sq_q;
  logic signed [IN_W-1:0]  s1_ax_q;
  logic                    s1_zero_q;
  logic signed [PROD_W-1:0] s1_prod_q;
  logic signed [2*IN_W-1:0] ay_sq;
  logic signed [2*IN_W-1:0] az_sq;

  // Second stage: radicand and finished rate.
  logic signed [RATE_W:0]   rate_shifted;
  logic signed [RATE_W+1:0] rate_signed;
  logic signed [RATE_W-1:0] rate_sat;
  logic                     s2_valid_q;
  logic [REM_W-1:0]         s2_rem_q;
  logic signed [IN_W-1:0]   s2_ax_q;
  tag_t                     s2_tag_q;

  // Square-root chain, element 0 is its input.
  logic                   sq_valid [ROOT_W+1];
  logic [REM_W-1:0]       sq_rem   [ROOT_W+1];
  logic [ROOT_W-1:0]      sq_root  [ROOT_W+1];
  logic signed [IN_W-1:0] sq_ax    [ROOT_W+1];
  tag_t                   sq_tag   [ROOT_W+1];

  // CORDIC chain, element 0 is its input.
  logic                  cd_valid [CORDIC_CELLS+1];
  logic signed [X_W-1:0] cd_x     [CORDIC_CELLS+1];
  logic signed [X_W-1:0] cd_y     [CORDIC_CELLS+1];
  logic signed [Z_W-1:0] cd_z     [CORDIC_CELLS+1];
  tag_t                  cd_tag   [CORDIC_CELLS+1];

  // Output stage.
  logic signed [Z_W:0]       z_round;
  logic signed [Z_W-8:0]     angle_q88;
  logic signed [ANGLE_W-1:0] angle_clamped;
  logic signed [ANGLE_W-1:0] angle_d;
  logic                      result_valid_q;
  logic signed [ANGLE_W-1:0] pitch_angle_q;
  logic signed [RATE_W-1:0]  pitch_rate_q;

  // The block never holds off a start.
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      negate_angle_q <= 1'b0;
      negate_rate_q  <= 1'b0;
      rate_recip_q   <= RATE_RECIP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_NEGATE_ANGLE: negate_angle_q <= cfg_wdata_i[0];
        REG_NEGATE_RATE:  negate_rate_q  <= cfg_wdata_i[0];
        REG_RATE_RECIP:   rate_recip_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage one. Each square is at most 2^30, so it fits in 31 bits.
  assign ay_sq = accel_y_i * accel_y_i;
  assign az_sq = accel_z_i * accel_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ay_sq_q <= ay_sq[SQ_W-2:0];
    s1_az_sq_q <= az_sq[SQ_W-2:0];
    s1_ax_q    <= accel_x_i;
    s1_zero_q  <= (accel_x_i == '0) && (accel_y_i == '0) && (accel_z_i == '0);
    s1_prod_q  <= gyro_pitch_i * $signed({1'b0, rate_recip_q});
  end

  // Stage two. The rate is floored by the arithmetic shift, then negated
  // and saturated to 24 bits; negating the most negative code saturates.
  assign rate_shifted = s1_prod_q[PROD_W-1:16];
  assign rate_signed  = negate_rate_q ? -(RATE_W + 2)'(rate_shifted)
                                      :  (RATE_W + 2)'(rate_shifted);

  always_comb begin
    if (rate_signed > (RATE_W + 2)'(2 ** (RATE_W - 1) - 1)) begin
      rate_sat = {1'b0, {(RATE_W - 1){1'b1}}};
    end else if (rate_signed < -(RATE_W + 2)'(2 ** (RATE_W - 1))) begin
      rate_sat = {1'b1, {(RATE_W - 1){1'b0}}};
    end else begin
      rate_sat = rate_signed[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    s2_rem_q      <= {SQ_W'(s1_ay_sq_q) + SQ_W'(s1_az_sq_q), 16'b0};
    s2_ax_q       <= s1_ax_q;
    s2_tag_q.zero <= s1_zero_q;
    s2_tag_q.rate <= rate_sat;
  end

  // Square-root chain: cell j settles root bit ROOT_W-1-j, most significant
  // first. The result is the exact floor of the root.
  assign sq_valid[0] = s2_valid_q;
  assign sq_rem[0]   = s2_rem_q;
  assign sq_root[0]  = '0;
  assign sq_ax[0]    = s2_ax_q;
  assign sq_tag[0]   = s2_tag_q;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    apag_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bit_i   (BIT_W'(ROOT_W - 1 - j)),
      .valid_i (sq_valid[j]),
      .rem_i   (sq_rem[j]),
      .root_i  (sq_root[j]),
      .ax_i    (sq_ax[j]),
      .tag_i   (sq_tag[j]),
      .valid_o (sq_valid[j+1]),
      .rem_o   (sq_rem[j+1]),
      .root_o  (sq_root[j+1]),
      .ax_o    (sq_ax[j+1]),
      .tag_o   (sq_tag[j+1])
    );
  end

  // CORDIC chain: the vector (root, ax * 256) is rotated onto the x axis
  // and the accumulated rotation is the angle in Q16 degrees.
  assign cd_valid[0] = sq_valid[ROOT_W];
  assign cd_x[0]     = $signed(X_W'(sq_root[ROOT_W]));
  assign cd_y[0]     = X_W'($signed({sq_ax[ROOT_W], 8'b0}));
  assign cd_z[0]     = '0;
  assign cd_tag[0]   = sq_tag[ROOT_W];

  for (genvar j = 0; j < CORDIC_CELLS; j++) begin : g_cordic
    apag_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (STEP_W'(j)),
      .valid_i (cd_valid[j]),
      .x_i     (cd_x[j]),
      .y_i     (cd_y[j]),
      .z_i     (cd_z[j]),
      .tag_i   (cd_tag[j]),
      .valid_o (cd_valid[j+1]),
      .x_o     (cd_x[j+1]),
      .y_o     (cd_y[j+1]),
      .z_o     (cd_z[j+1]),
      .tag_o   (cd_tag[j+1])
    );
  end

  // Round Q16 to Q8.8 (floor of z/256 + 1/2), clamp to 90 degrees, then
  // apply the mounting sign. An all-zero sample reads as level.
  assign z_round   = (Z_W + 1)'(cd_z[CORDIC_CELLS]) + (Z_W + 1)'(128);
  assign angle_q88 = z_round[Z_W:8];

  always_comb begin
    if (angle_q88 > (Z_W - 7)'(ANGLE_LIMIT)) begin
      angle_clamped = ANGLE_W'(ANGLE_LIMIT);
    end else if (angle_q88 < -(Z_W - 7)'(ANGLE_LIMIT)) begin
      angle_clamped = -ANGLE_W'(ANGLE_LIMIT);
    end else begin
      angle_clamped = angle_q88[ANGLE_W-1:0];
    end
    if (cd_tag[CORDIC_CELLS].zero) begin
      angle_d = '0;
    end else if (negate_angle_q) begin
      angle_d = -angle_clamped;
    end else begin
      angle_d = angle_clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cd_valid[CORDIC_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    pitch_angle_q <= angle_d;
    pitch_rate_q  <= cd_tag[CORDIC_CELLS].rate;
  end

  assign result_valid_o = result_valid_q;
  assign pitch_angle_o  = pitch_angle_q;
  assign pitch_rate_o   = pitch_rate_q;

  // Every accepted item is followed by its result strobe.
  a_result_follows_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY result_valid_o)
    else $error("accepted item gave no result strobe");

  // A result strobe only ever follows an accepted item.
  a_no_stray_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy && rst_ni, LATENCY))
    else $error("result strobe does not follow an accepted item");

  // The angle never leaves plus or minus 90 degrees.
  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (pitch_angle_o <= ANGLE_W'(ANGLE_LIMIT)) &&
                       (pitch_angle_o >= -ANGLE_W'(ANGLE_LIMIT)))
    else $error("pitch angle out of range");

  // An all-zero accelerometer sample yields a zero angle.
  a_zero_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start && !busy && rst_ni && (accel_x_i == '0) && (accel_y_i == '0)
          && (accel_z_i == '0), LATENCY) |-> (pitch_angle_o == '0))
    else $error("all-zero sample gave a nonzero angle");

endmodule

// File: sim/accel_pitch_angle_and_gyro_rate_tb.sv
// Self-checking testbench for the pitch angle and gyro rate block.
// Depends on apag_pkg and accel_pitch_angle_and_gyro_rate; a built-in
// predictor supplies the expected angle and rate for every sample.
`timescale 1ns / 100ps

module accel_pitch_angle_and_gyro_rate_tb;

  import apag_pkg::*;

  // Register index past the end of the map; writes to it must change nothing.
  localparam logic [1:0] REG_INDEX_SPARE = 2'd3;

  localparam logic [RECIP_W-1:0] RATE_RECIP_AT_RESET = 24'd128075;
  localparam logic [RECIP_W-1:0] RATE_RECIP_MAX      = 24'hFFFFFF;

  // Micro-rotations in the angle predictor and the output range limits.
  localparam int    ANGLE_ROTATIONS = 16;
  localparam int    ANGLE_CLAMP     = 23040;
  localparam longint RATE_CEIL      = 64'sd8388607;
  localparam longint RATE_FLOOR     = -64'sd8388608;

  // Cycles without any accepted item or result before the run is abandoned.
  // The slowest correct stretch is a long sender gap or a drain of the
  // pipeline followed by register writes.
  localparam int WATCHDOG_LIMIT = 1000;

  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 222;
  localparam int MAX_PRINTED_MISS = 50;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [RATE_W-1:0]  rate;
  } pitch_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic signed [IN_W-1:0]     accel_x_i = '0;
  logic signed [IN_W-1:0]     accel_y_i = '0;
  logic signed [IN_W-1:0]     accel_z_i = '0;
  logic signed [IN_W-1:0]     gyro_pitch_i = '0;
  logic                       cfg_we_i = 1'b0;
  logic [1:0]                 cfg_index_i = '0;
  logic [RECIP_W-1:0]         cfg_wdata_i = '0;
  logic                       result_valid_o;
  logic signed [ANGLE_W-1:0]  pitch_angle_o;
  logic signed [RATE_W-1:0]   pitch_rate_o;

  // The predictor's own copy of the configuration registers.
  logic               cfg_negate_angle = 1'b0;
  logic               cfg_negate_rate  = 1'b0;
  logic [RECIP_W-1:0] cfg_rate_recip   = RATE_RECIP_AT_RESET;

  // Angle and rate results owed by the block, oldest first.
  pitch_result_t pitch_results_due[$];
  int            mismatch_count = 0;
  int            quiet_cycles   = 0;

  accel_pitch_angle_and_gyro_rate dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .accel_x_i      (accel_x_i),
    .accel_y_i      (accel_y_i),
    .accel_z_i      (accel_z_i),
    .gyro_pitch_i   (gyro_pitch_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .pitch_angle_o  (pitch_angle_o),
    .pitch_rate_o   (pitch_rate_o)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Arctangent of 2^-i in degrees, scaled by 2^16 and rounded.
  function automatic longint atan_deg_q16(input int step);
    case (step)
      0:  return 2949120;
      1:  return 1740967;
      2:  return 919879;
      3:  return 466945;
      4:  return 234379;
      5:  return 117304;
      6:  return 58666;
      7:  return 29335;
      8:  return 14668;
      9:  return 7334;
      10: return 3667;
      11: return 1833;
      12: return 917;
      13: return 458;
      14: return 229;
      15: return 115;
      default: return 0;
    endcase
  endfunction

  // Works out the angle and rate that one sample must produce under the
  // current register settings.
  function automatic pitch_result_t expected_pitch_and_rate(
      input logic signed [IN_W-1:0] ax, input logic signed [IN_W-1:0] ay,
      input logic signed [IN_W-1:0] az, input logic signed [IN_W-1:0] g);
    longint unsigned radicand;
    longint unsigned root;
    longint unsigned trial;
    longint x, y, z, nx, ny;
    longint ang, rate;
    pitch_result_t res;
    if (ax == 0 && ay == 0 && az == 0) begin
      // With no gravity vector the angle is defined as level.
      ang = 0;
    end else begin
      // Horizontal magnitude scaled by 256, as an exact floored square root
      // of (ay^2 + az^2) * 2^16, built one root bit at a time.
      radicand = longint'(longint'(ay) * longint'(ay) + longint'(az) * longint'(az));
      radicand = radicand << 16;
      root = 0;
      for (int b = 23; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= radicand) root = trial;
      end
      // Vectoring rotations drive y to zero and collect the angle in z.
      x = longint'(root);
      y = longint'(ax) * 256;
      z = 0;
      for (int i = 0; i < ANGLE_ROTATIONS; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z  = z + atan_deg_q16(i);
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z  = z - atan_deg_q16(i);
        end
        x = nx;
        y = ny;
      end
      // Round from Q16 to Q8.8 and keep within plus or minus 90 degrees.
      ang = (z + 128) >>> 8;
      if (ang > ANGLE_CLAMP) ang = ANGLE_CLAMP;
      if (ang < -ANGLE_CLAMP) ang = -ANGLE_CLAMP;
    end
    if (cfg_negate_angle) ang = -ang;

    rate = (longint'(g) * longint'(cfg_rate_recip)) >>> 16;
    if (cfg_negate_rate) rate = -rate;
    if (rate > RATE_CEIL) rate = RATE_CEIL;
    if (rate < RATE_FLOOR) rate = RATE_FLOOR;

    res.angle = ang[ANGLE_W-1:0];
    res.rate  = rate[RATE_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Checking and watchdog
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED_MISS) $display("%0t MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Everything here samples the values that were settled before the edge,
  // so the order of processes within the edge does not matter.
  always @(posedge clk_i) begin
    pitch_result_t want;
    bit            progressed;
    progressed = 1'b0;
    if (rst_ni) begin
      // An item is taken whenever start meets a block that is not busy.
      if (start && !busy) begin
        pitch_results_due.push_back(expected_pitch_and_rate(accel_x_i, accel_y_i,
                                                            accel_z_i, gyro_pitch_i));
        progressed = 1'b1;
      end
      // Results cannot be held off, so each one is taken in its only cycle.
      if (result_valid_o) begin
        progressed = 1'b1;
        if (pitch_results_due.size() == 0) begin
          report_mismatch($sformatf("result angle %0d rate %0d with nothing outstanding",
                                    pitch_angle_o, pitch_rate_o));
        end else begin
          want = pitch_results_due.pop_front();
          if (pitch_angle_o !== want.angle)
            report_mismatch($sformatf("pitch_angle got %0d, expected %0d",
                                      pitch_angle_o, want.angle));
          if (pitch_rate_o !== want.rate)
            report_mismatch($sformatf("pitch_rate got %0d, expected %0d",
                                      pitch_rate_o, want.rate));
        end
      end
      // Register writes land at this edge; they only happen while no item is
      // in flight, so updating the predictor after the prediction is safe.
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_NEGATE_ANGLE: cfg_negate_angle = cfg_wdata_i[0];
          REG_NEGATE_RATE:  cfg_negate_rate  = cfg_wdata_i[0];
          REG_RATE_RECIP:   cfg_rate_recip   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (progressed) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no item or result for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Presents one sample and returns at the edge that accepts it. Start stays
  // high, so a following call with no pause sends back to back.
  task automatic send_sample(input logic signed [IN_W-1:0] ax,
                             input logic signed [IN_W-1:0] ay,
                             input logic signed [IN_W-1:0] az,
                             input logic signed [IN_W-1:0] g);
    start        <= 1'b1;
    accel_x_i    <= ax;
    accel_y_i    <= ay;
    accel_z_i    <= az;
    gyro_pitch_i <= g;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Holds the sender off until every outstanding result has come back.
  // The queue is looked at on falling edges, away from the monitor.
  task automatic wait_until_idle();
    start <= 1'b0;
    do @(negedge clk_i); while (pitch_results_due.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [RECIP_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A raw axis value: often fully random, otherwise small, zero or near
  // either end of the range.
  function automatic logic signed [IN_W-1:0] random_axis();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return IN_W'($urandom);
      5:       return IN_W'(int'($urandom_range(0, 16)) - 8);
      6:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      7:       return '0;
      8:       return IN_W'(32767 - int'($urandom_range(0, 64)));
      default: return IN_W'(-32768 + int'($urandom_range(0, 64)));
    endcase
  endfunction

  function automatic logic [RECIP_W-1:0] random_recip();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return RATE_RECIP_MAX;
      2:       return RATE_RECIP_AT_RESET;
      3:       return RECIP_W'($urandom_range(0, 1023));
      default: return RECIP_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Angle corners under the reset settings: the all-zero sample, vertical
  // and horizontal gravity, the smallest nonzero tilts and full-scale axes.
  // The gyro values run through its extremes at the same time.
  task automatic test_angle_corners();
    send_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh0000, 16'sh0000, 16'sh8000);
    pause_sender(2);
    send_sample(16'sh0000, 16'sh7FFF, 16'sh0000, -16'sd1);
    send_sample(16'sh0000, 16'sh0000, 16'sh8000, 16'sd1);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    pause_sender(5);
    send_sample(16'sd1, 16'sh0000, 16'sh0000, 16'sd100);
    send_sample(-16'sd1, 16'sh0000, 16'sh0000, -16'sd100);
    send_sample(16'sd1, 16'sh8000, 16'sh0000, 16'sh0000);
    send_sample(16'sh8000, 16'sd1, 16'sd1, 16'sh7FFF);
  endtask

  // Rate corners: the largest reciprocal with both signs flipped, where the
  // most negative product negates past the top of the range and must
  // saturate, then the next smaller reciprocal, whose product just stays in
  // range, and a zero reciprocal.
  task automatic test_rate_extremes();
    wait_until_idle();
    write_register(REG_NEGATE_ANGLE, 24'd1);
    write_register(REG_NEGATE_RATE, 24'd1);
    write_register(REG_RATE_RECIP, RATE_RECIP_MAX);
    send_sample(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF);
    send_sample(16'sh1234, 16'sh8000, 16'sh7FFF, 16'sh8000);
    wait_until_idle();
    write_register(REG_RATE_RECIP, RATE_RECIP_MAX - 24'd1);
    send_sample(16'sh8000, 16'sh0000, 16'sh0001, 16'sh8000);
    wait_until_idle();
    write_register(REG_RATE_RECIP, '0);
    send_sample(16'sh4000, 16'sh4000, 16'sh0000, 16'sh8000);
  endtask

  // Only bit 0 of the flag registers counts, and a write to the spare index
  // must leave every register as it was.
  task automatic test_register_decode();
    wait_until_idle();
    write_register(REG_NEGATE_ANGLE, 24'hFFFFFE);
    write_register(REG_NEGATE_RATE, 24'hFFFFFF);
    write_register(REG_RATE_RECIP, RATE_RECIP_AT_RESET);
    write_register(REG_INDEX_SPARE, 24'hFFFFFF);
    send_sample(16'sh2000, 16'sh1000, 16'shF000, 16'sh7FFF);
    wait_until_idle();
    write_register(REG_INDEX_SPARE, 24'h000000);
    send_sample(16'shE000, 16'sh0100, 16'sh3000, 16'sh8000);
  endtask

  // Random samples in several phases. Each phase starts from an empty
  // pipeline with fresh register values; the first two pin the extremes and
  // one phase runs with no gaps at all.
  task automatic test_random_samples();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_until_idle();
      case (phase)
        0: begin
          write_register(REG_NEGATE_ANGLE, 24'd1);
          write_register(REG_NEGATE_RATE, 24'd1);
          write_register(REG_RATE_RECIP, RATE_RECIP_MAX);
        end
        1: begin
          write_register(REG_NEGATE_ANGLE, 24'd0);
          write_register(REG_NEGATE_RATE, 24'd0);
          write_register(REG_RATE_RECIP, '0);
        end
        default: begin
          write_register(REG_NEGATE_ANGLE, RECIP_W'($urandom));
          write_register(REG_NEGATE_RATE, RECIP_W'($urandom));
          write_register(REG_RATE_RECIP, random_recip());
          if ($urandom_range(0, 1)) write_register(REG_INDEX_SPARE, RECIP_W'($urandom));
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_sample(random_axis(), random_axis(), random_axis(), random_axis());
        if (phase != 2) pause_sender(random_gap());
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_angle_corners();
    test_rate_extremes();
    test_register_decode();
    test_random_samples();

    // Let the pipeline empty, then watch a little longer for stray results.
    wait_until_idle();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (pitch_results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pitch_results_due.size()));

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/apag_pkg.sv
rtl/apag_sqrt_cell.sv
rtl/apag_cordic_cell.sv
rtl/accel_pitch_angle_and_gyro_rate.sv
sim/accel_pitch_angle_and_gyro_rate_tb.sv
